/* hw/rtl/maf_pkg.sv */
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and fixed constants of the moving-average setpoint block.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int OFFSET_W     = 15;
  localparam int SPAN_W       = 8;
  localparam int MEAN_W       = 20;
  localparam int FREQ_W       = 17;
  localparam int PROD_W       = MEAN_W + SPAN_W;
  localparam int FULL_SCALE_W = 12;
  localparam int FULL_SCALE   = 4095;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SPAN   = 1'b1;

  localparam logic [OFFSET_W-1:0] FREQ_OFFSET_RESET = 15'd1536;
  localparam logic [SPAN_W-1:0]   FREQ_SPAN_RESET   = 8'd114;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_MEAN,
    ST_MUL,
    ST_DIV_FREQ,
    ST_DONE
  } maf_state_t;

endpackage

/* hw/rtl/maf_ring.sv */
// ----------------------------------------------------------------------------
// maf_ring
// Sample ring memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module maf_ring #(
  parameter int DEPTH = 50,
  parameter int AW    = 6,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/maf_serial_div.sv */
// ----------------------------------------------------------------------------
// maf_serial_div
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module maf_serial_div #(
  parameter int DW = 28,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  // The partial remainder stays below the divisor, so the difference fits VW bits.
  assign trial = {rem, quotient[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], ge};
      rem      <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

/* hw/rtl/maf_serial_mul.sv */
// ----------------------------------------------------------------------------
// maf_serial_mul
// Shift-and-add multiplier that consumes one multiplier bit per clock cycle.
// ----------------------------------------------------------------------------
module maf_serial_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [maf_pkg::MEAN_W-1:0]      mcand,
  input  logic [maf_pkg::SPAN_W-1:0]      mplier,
  output logic                            done,
  output logic [maf_pkg::PROD_W-1:0]      product
);

  localparam int CNT_W = $clog2(maf_pkg::SPAN_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [maf_pkg::PROD_W-1:0] mc;
  logic [maf_pkg::SPAN_W-1:0] mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(maf_pkg::SPAN_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mc      <= maf_pkg::PROD_W'(mcand);
      mp      <= mplier;
    end else if (busy) begin
      if (mp[0]) begin
        product <= product + mc;
      end
      mc <= {mc[maf_pkg::PROD_W-2:0], 1'b0};
      mp <= {1'b0, mp[maf_pkg::SPAN_W-1:1]};
    end
  end

endmodule

/* hw/rtl/moving_average_freq_setpoint_core.sv */
// ----------------------------------------------------------------------------
// moving_average_freq_setpoint_core
// Windowed mean of converter samples mapped linearly to a frequency setpoint.
// ----------------------------------------------------------------------------
// Each accepted sample request enters a ring of the last WINDOW samples and
// updates a running sum. The mean is the sum in Q.8 divided by the number of
// samples seen so far, or by WINDOW once the ring has filled, rounded down.
// The setpoint is freq_offset_q8 + floor(mean_q8 * freq_span_hz / 4095) in
// Q.8 hertz. One request is processed at a time. The shared bit-serial
// divider (28 bits wide for WINDOW up to 256) runs once for the mean and
// once for the setpoint scaling, with the serial multiply over the 8-bit
// span in between. A finished result sits in an output register, so the
// next sample request is taken while the previous result is still waiting.
// The ring needs no clearing after reset since entries are only read once
// written.
// ----------------------------------------------------------------------------
module moving_average_freq_setpoint_core #(
  parameter int WINDOW = 50
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [maf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [maf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [maf_pkg::SAMPLE_W-1:0]      adc_sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [maf_pkg::MEAN_W-1:0]        mean_q8,
  output logic [maf_pkg::FREQ_W-1:0]        freq_setpoint_q8,
  output logic                              window_full
);

  // Sum must hold WINDOW full-scale samples; the count must hold WINDOW itself.
  localparam int SUM_W  = $clog2(WINDOW * maf_pkg::FULL_SCALE + 1);
  localparam int POS_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int DIV_DW = (SUM_W + 8 > maf_pkg::PROD_W) ? SUM_W + 8 : maf_pkg::PROD_W;
  localparam int DIV_VW = (CNT_W > maf_pkg::FULL_SCALE_W) ? CNT_W : maf_pkg::FULL_SCALE_W;

  maf_pkg::maf_state_t state, state_next;

  // Configuration registers.
  logic [maf_pkg::OFFSET_W-1:0] freq_offset;
  logic [maf_pkg::SPAN_W-1:0]   freq_span;

  // Filter state.
  logic [SUM_W-1:0]             running_sum;
  logic [SUM_W-1:0]             running_sum_next;
  logic [POS_W-1:0]             write_position;
  logic                         ring_filled;
  logic [maf_pkg::SAMPLE_W-1:0] sample;
  logic [maf_pkg::SAMPLE_W-1:0] old_sample;
  logic [CNT_W-1:0]             count;

  // Results of the current request before they move to the output register.
  logic [maf_pkg::MEAN_W-1:0]   mean_hold;
  logic [maf_pkg::FREQ_W-1:0]   freq_hold;
  logic                         full_hold;

  // Datapath control.
  logic                         accept;
  logic                         ring_we;
  logic                         div_start;
  logic [DIV_DW-1:0]            div_dividend;
  logic [DIV_VW-1:0]            div_divisor;
  logic                         div_done;
  logic [DIV_DW-1:0]            div_quotient;
  logic                         mul_start;
  logic                         mul_done;
  logic [maf_pkg::PROD_W-1:0]   mul_product;
  logic                         load_result;

  assign accept = sample_valid && sample_ready;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_offset <= maf_pkg::FREQ_OFFSET_RESET;
      freq_span   <= maf_pkg::FREQ_SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        maf_pkg::CFG_FREQ_OFFSET: freq_offset <= cfg_data[maf_pkg::OFFSET_W-1:0];
        maf_pkg::CFG_FREQ_SPAN:   freq_span   <= cfg_data[maf_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // The ring is read at the acceptance edge and written in the next cycle, so
  // the entry about to be overwritten is available for the sum update.
  maf_ring #(
    .DEPTH (WINDOW),
    .AW    (POS_W),
    .DW    (maf_pkg::SAMPLE_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_position),
    .wdata (sample),
    .re    (accept),
    .raddr (write_position),
    .rdata (old_sample)
  );

  // The oldest sample is dropped only after the ring has wrapped once. The
  // intermediate may wrap, but the final sum always fits SUM_W bits.
  always_comb begin
    running_sum_next = running_sum + SUM_W'(sample);
    if (ring_filled) begin
      running_sum_next = running_sum_next - SUM_W'(old_sample);
    end
  end

  assign count = ring_filled ? CNT_W'(WINDOW) : CNT_W'(write_position) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      write_position <= '0;
      ring_filled    <= 1'b0;
    end else if (state == maf_pkg::ST_SUM) begin
      running_sum <= running_sum_next;
      if (write_position == POS_W'(WINDOW - 1)) begin
        write_position <= '0;
        ring_filled    <= 1'b1;
      end else begin
        write_position <= write_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= adc_sample;
    end
    if (state == maf_pkg::ST_SUM) begin
      full_hold <= ring_filled || (write_position == POS_W'(WINDOW - 1));
    end
    if ((state == maf_pkg::ST_DIV_MEAN) && div_done) begin
      mean_hold <= div_quotient[maf_pkg::MEAN_W-1:0];
    end
    if ((state == maf_pkg::ST_DIV_FREQ) && div_done) begin
      freq_hold <= maf_pkg::FREQ_W'(freq_offset) + div_quotient[maf_pkg::FREQ_W-1:0];
    end
  end

  // One divider serves both the mean and the scaling by full scale.
  maf_serial_div #(
    .DW (DIV_DW),
    .VW (DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The multiply starts in the cycle the mean leaves the divider, so it takes
  // the mean straight from the quotient.
  maf_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (div_quotient[maf_pkg::MEAN_W-1:0]),
    .mplier  (freq_span),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      maf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = maf_pkg::ST_SUM;
        end
      end
      maf_pkg::ST_SUM: begin
        state_next = maf_pkg::ST_DIV_MEAN;
      end
      maf_pkg::ST_DIV_MEAN: begin
        if (div_done) begin
          state_next = maf_pkg::ST_MUL;
        end
      end
      maf_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = maf_pkg::ST_DIV_FREQ;
        end
      end
      maf_pkg::ST_DIV_FREQ: begin
        if (div_done) begin
          state_next = maf_pkg::ST_DONE;
        end
      end
      maf_pkg::ST_DONE: begin
        if (load_result) begin
          state_next = maf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = maf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    ring_we      = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    load_result  = 1'b0;
    div_dividend = DIV_DW'(mul_product);
    div_divisor  = DIV_VW'(maf_pkg::FULL_SCALE);
    case (state)
      maf_pkg::ST_IDLE: begin
        sample_ready = !rst;
      end
      maf_pkg::ST_SUM: begin
        ring_we      = 1'b1;
        div_start    = 1'b1;
        div_dividend = DIV_DW'({running_sum_next, 8'd0});
        div_divisor  = DIV_VW'(count);
      end
      maf_pkg::ST_DIV_MEAN: begin
        mul_start = div_done;
      end
      maf_pkg::ST_MUL: begin
        div_start = mul_done;
      end
      maf_pkg::ST_DIV_FREQ: begin
      end
      maf_pkg::ST_DONE: begin
        load_result = !result_valid || result_ready;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_full <= 1'b0;
    end else if (load_result) begin
      window_full <= full_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      mean_q8          <= mean_hold;
      freq_setpoint_q8 <= freq_hold;
    end
  end

endmodule

/* hw/rtl/maf_checker.sv */
// ----------------------------------------------------------------------------
// maf_checker
// Port-level checks of the moving-average setpoint block, bound to its top.
// ----------------------------------------------------------------------------
module maf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [maf_pkg::MEAN_W-1:0]     mean_q8,
  input logic [maf_pkg::FREQ_W-1:0]     freq_setpoint_q8,
  input logic                           window_full
);

  // A waiting result must not change under a stall.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(mean_q8)
      && $stable(freq_setpoint_q8) && $stable(window_full))
    else $error("result changed while stalled");

  // Once the window has filled it stays filled until reset.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    window_full |=> window_full)
    else $error("window_full dropped");

  // A sample request is processed alone, so ready drops right after acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second request taken while busy");

  // The mean of 12-bit samples never exceeds full scale in Q.8.
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mean_q8 <= 20'd1048320)
    else $error("mean out of range");

endmodule

bind moving_average_freq_setpoint_core maf_checker u_maf_checker (.*);
